// ===== src/svam_pkg.sv =====
// Shared widths, register map codes, reset values and types for the supply voltage alarm monitor.
package svam_pkg;

   localparam int SAMPLE_W     = 16;
   localparam int SAMPLE_MAX   = 65535;
   localparam int THRESH_W     = 13;
   localparam int COUNT_W      = 8;
   localparam int TENTHS_W     = 14;
   // The trimmed mean never exceeds 65535 mV, so 655 tenths fit in ten bits.
   localparam int VOLT_W       = 10;
   localparam int MV_PER_TENTH = 100;

   localparam int CSR_DATA_W   = 32;
   localparam int CSR_ADDR_W   = 5;
   localparam int CSR_INDEX_W  = 3;

   localparam logic [CSR_INDEX_W-1:0] REG_LOW_THRESHOLD  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SHUT_THRESHOLD = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_QUALIFY_COUNT  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_LOW_MARGIN     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_SHUT_MARGIN    = 3'd4;

   localparam logic [THRESH_W-1:0] LOW_THRESHOLD_RESET  = 13'd0;
   localparam logic [THRESH_W-1:0] SHUT_THRESHOLD_RESET = 13'd50;
   localparam logic [COUNT_W-1:0]  QUALIFY_COUNT_RESET  = 8'd150;
   localparam logic [COUNT_W-1:0]  LOW_MARGIN_RESET     = 8'd2;
   localparam logic [COUNT_W-1:0]  SHUT_MARGIN_RESET    = 8'd10;

   typedef struct packed {
      logic [THRESH_W-1:0] low_threshold;
      logic [THRESH_W-1:0] shut_threshold;
      logic [COUNT_W-1:0]  qualify_count;
      logic [COUNT_W-1:0]  low_margin;
      logic [COUNT_W-1:0]  shut_margin;
   } cfg_type;

   typedef struct packed {
      logic shut;
      logic low;
   } alarm_type;

endpackage

// ===== src/supply_voltage_alarm_monitor_unit.sv =====
// Top level of the supply voltage alarm monitor: sample ring, trimmed mean pipeline and CSRs.
module supply_voltage_alarm_monitor_unit #(
   parameter int WINDOW = 6
) (
   input  logic                              clock,
   input  logic                              reset,
   // Sample stream in. tdata: adc_sample[15:0].
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [svam_pkg::SAMPLE_W-1:0]     req_tdata,
   // Result stream out. tdata: voltage_tenths[13:0], low_alarm[14], shut_alarm[15].
   // tuser: evaluated[0].
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [15:0]                       rsp_tdata,
   output logic                              rsp_tuser,
   // Configuration port.
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [svam_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [svam_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [svam_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   // This block watches a supply rail sampled in millivolts and raises an
   // undervoltage alarm or a power-cut alarm once the filtered voltage has
   // stayed in the matching band for qualify_count evaluations in a row;
   // each alarm clears again only after the same count of evaluations above
   // its threshold plus margin, and a power-cut alarm always clears the
   // undervoltage alarm. Every sample transfer produces exactly one result
   // transfer, in order. The first WINDOW samples after reset only fill the
   // sample ring: their results carry evaluated = 0, a voltage of zero and
   // the held alarm state. From then on each sample is averaged with the
   // WINDOW-1 before it after dropping the smallest and largest, and the
   // result is reported in tenths of a volt (truncated). The block takes one
   // sample per clock cycle while the output is not stalled; each result
   // passes through the four pipeline stages (ring min/max/sum, reciprocal
   // multiply, remainder correction, qualifiers) and a result register.
   // A result waiting on a stalled output does not stop new samples from
   // entering until the stages in front of it are full.
   // Configuration registers sit at byte addresses 0x00 low_threshold,
   // 0x04 shut_threshold, 0x08 qualify_count, 0x0C low_margin and
   // 0x10 shut_margin; they may be written only while no sample is in flight.
   import svam_pkg::*;

   localparam int PTR_W    = $clog2(WINDOW);
   localparam int FILL_W   = $clog2(WINDOW + 1);
   localparam int SUM_W    = $clog2(WINDOW * SAMPLE_MAX + 1);
   localparam int TRIM_W   = $clog2((WINDOW - 2) * SAMPLE_MAX + 1);
   localparam int DIVISOR  = (WINDOW - 2) * MV_PER_TENTH;
   // floor(2^TRIM_W / DIVISOR) gives a quotient that is exact or one short.
   localparam int RECIP    = (1 << TRIM_W) / DIVISOR;
   localparam int RECIP_W  = $clog2(RECIP + 1);
   localparam int PROD_W   = TRIM_W + RECIP_W;

   localparam logic [TRIM_W-1:0] DIVISOR_V  = TRIM_W'(DIVISOR);
   localparam logic [PROD_W-1:0] RECIP_V    = PROD_W'(RECIP);
   localparam logic [PTR_W-1:0]  PTR_LAST   = PTR_W'(WINDOW - 1);
   localparam logic [FILL_W-1:0] FILL_FULL  = FILL_W'(WINDOW);

   // ---------------------------------------------------------------- CSRs
   cfg_type                 cfg_ff;
   logic                    csr_write;
   logic [CSR_INDEX_W-1:0]  csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.low_threshold  <= LOW_THRESHOLD_RESET;
         cfg_ff.shut_threshold <= SHUT_THRESHOLD_RESET;
         cfg_ff.qualify_count  <= QUALIFY_COUNT_RESET;
         cfg_ff.low_margin     <= LOW_MARGIN_RESET;
         cfg_ff.shut_margin    <= SHUT_MARGIN_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_LOW_THRESHOLD:  cfg_ff.low_threshold  <= csr_pwdata[THRESH_W-1:0];
            REG_SHUT_THRESHOLD: cfg_ff.shut_threshold <= csr_pwdata[THRESH_W-1:0];
            REG_QUALIFY_COUNT:  cfg_ff.qualify_count  <= csr_pwdata[COUNT_W-1:0];
            REG_LOW_MARGIN:     cfg_ff.low_margin     <= csr_pwdata[COUNT_W-1:0];
            REG_SHUT_MARGIN:    cfg_ff.shut_margin    <= csr_pwdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_LOW_THRESHOLD:  csr_prdata = CSR_DATA_W'(cfg_ff.low_threshold);
         REG_SHUT_THRESHOLD: csr_prdata = CSR_DATA_W'(cfg_ff.shut_threshold);
         REG_QUALIFY_COUNT:  csr_prdata = CSR_DATA_W'(cfg_ff.qualify_count);
         REG_LOW_MARGIN:     csr_prdata = CSR_DATA_W'(cfg_ff.low_margin);
         REG_SHUT_MARGIN:    csr_prdata = CSR_DATA_W'(cfg_ff.shut_margin);
         default:            csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------ pipeline flow
   // Each stage moves on when the stage after it is empty or moving on.
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, rsp_valid_ff;
   logic rsp_free, s4_free, s3_free, s2_free, s1_free;
   logic req_accept;

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign s4_free    = !s4_valid_ff || rsp_free;
   assign s3_free    = !s3_valid_ff || s4_free;
   assign s2_free    = !s2_valid_ff || s3_free;
   assign s1_free    = !s1_valid_ff || s2_free;
   assign req_tready = s1_free;
   assign req_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_free)  s1_valid_ff  <= req_tvalid;
         if (s2_free)  s2_valid_ff  <= s1_valid_ff;
         if (s3_free)  s3_valid_ff  <= s2_valid_ff;
         if (s4_free)  s4_valid_ff  <= s3_valid_ff;
         if (rsp_free) rsp_valid_ff <= s4_valid_ff;
      end
   end

   // ------------------------------------------------- stage 1: the ring
   // The sample is written at its transfer; stage 1 then reads the ring with
   // that sample already in place.
   logic [SAMPLE_W-1:0] ring_ff [WINDOW];
   logic [PTR_W-1:0]    wr_ptr_ff;
   logic [FILL_W-1:0]   fill_ff;
   logic                s1_eval_ff;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         ring_ff[wr_ptr_ff] <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         fill_ff   <= '0;
      end else if (req_accept) begin
         wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
         if (fill_ff != FILL_FULL) begin
            fill_ff <= fill_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_eval_ff <= (fill_ff == FILL_FULL);
      end
   end

   // Minimum, maximum and sum over the ring, then the trimmed sum.
   logic [SUM_W-1:0]    ring_sum;
   logic [SAMPLE_W-1:0] ring_min;
   logic [SAMPLE_W-1:0] ring_max;
   logic [SUM_W-1:0]    trim_full;

   always_comb begin
      ring_sum = '0;
      ring_min = SAMPLE_W'(SAMPLE_MAX);
      ring_max = '0;
      for (int i = 0; i < WINDOW; i++) begin
         ring_sum = ring_sum + SUM_W'(ring_ff[i]);
         if (ring_ff[i] < ring_min) ring_min = ring_ff[i];
         if (ring_ff[i] > ring_max) ring_max = ring_ff[i];
      end
      trim_full = ring_sum - SUM_W'(ring_min) - SUM_W'(ring_max);
   end

   logic              s2_eval_ff;
   logic [TRIM_W-1:0] s2_trim_ff;

   always_ff @(posedge clock) begin
      if (s2_free && s1_valid_ff) begin
         s2_eval_ff <= s1_eval_ff;
         s2_trim_ff <= trim_full[TRIM_W-1:0];
      end
   end

   // --------------------------- stage 2: multiply by the reciprocal
   logic [PROD_W-1:0] recip_prod;
   logic [PROD_W-1:0] recip_shift;
   logic              s3_eval_ff;
   logic [TRIM_W-1:0] s3_trim_ff;
   logic [VOLT_W-1:0] s3_quot_ff;

   assign recip_prod  = PROD_W'(s2_trim_ff) * RECIP_V;
   assign recip_shift = recip_prod >> TRIM_W;

   always_ff @(posedge clock) begin
      if (s3_free && s2_valid_ff) begin
         s3_eval_ff <= s2_eval_ff;
         s3_trim_ff <= s2_trim_ff;
         s3_quot_ff <= recip_shift[VOLT_W-1:0];
      end
   end

   // ------------------------------ stage 3: correct the estimate by one
   logic [TRIM_W-1:0] quot_times_div;
   logic [TRIM_W-1:0] remainder;
   logic [VOLT_W-1:0] volt_exact;
   logic              s4_eval_ff;
   logic [VOLT_W-1:0] s4_volt_ff;

   assign quot_times_div = TRIM_W'(s3_quot_ff) * DIVISOR_V;
   assign remainder      = s3_trim_ff - quot_times_div;
   assign volt_exact     = (remainder >= DIVISOR_V) ? s3_quot_ff + 1'b1 : s3_quot_ff;

   always_ff @(posedge clock) begin
      if (s4_free && s3_valid_ff) begin
         s4_eval_ff <= s3_eval_ff;
         s4_volt_ff <= volt_exact;
      end
   end

   // ------------------------------------ stage 4: qualifiers and result
   alarm_type         alarms_next;
   logic              qual_step;
   logic              rsp_eval_ff;
   logic [VOLT_W-1:0] rsp_volt_ff;
   alarm_type         rsp_alarms_ff;

   assign qual_step = s4_valid_ff && rsp_free && s4_eval_ff;

   svam_qual u_qual (
      .clock       (clock),
      .reset       (reset),
      .step        (qual_step),
      .voltage     (s4_volt_ff),
      .cfg         (cfg_ff),
      .alarms_next (alarms_next)
   );

   always_ff @(posedge clock) begin
      if (rsp_free && s4_valid_ff) begin
         rsp_eval_ff   <= s4_eval_ff;
         rsp_volt_ff   <= s4_eval_ff ? s4_volt_ff : '0;
         rsp_alarms_ff <= alarms_next;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_eval_ff;
   assign rsp_tdata  = {rsp_alarms_ff.shut, rsp_alarms_ff.low, TENTHS_W'(rsp_volt_ff)};

endmodule

// ===== src/svam_qual.sv =====
// Undervoltage and power-cut qualifiers with hysteresis, saturating counters and alarm flags.
module svam_qual (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  logic [svam_pkg::VOLT_W-1:0]    voltage,
   input  svam_pkg::cfg_type              cfg,
   output svam_pkg::alarm_type            alarms_next
);
   import svam_pkg::*;

   logic [COUNT_W-1:0] low_cnt_ff, low_cnt_in;
   logic [COUNT_W-1:0] low_clr_ff, low_clr_in;
   logic [COUNT_W-1:0] shut_cnt_ff, shut_cnt_in;
   logic [COUNT_W-1:0] shut_clr_ff, shut_clr_in;
   alarm_type          alarms_ff, alarms_in;

   logic [THRESH_W:0]  volt_ext;
   logic [THRESH_W:0]  low_ext;
   logic [THRESH_W:0]  shut_ext;
   logic [THRESH_W:0]  low_limit;
   logic [THRESH_W:0]  shut_limit;

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] cnt,
                                                 input logic [COUNT_W-1:0] lim);
      return (cnt < lim) ? cnt + 1'b1 : cnt;
   endfunction

   always_comb begin
      volt_ext   = (THRESH_W+1)'(voltage);
      low_ext    = (THRESH_W+1)'(cfg.low_threshold);
      shut_ext   = (THRESH_W+1)'(cfg.shut_threshold);
      // Threshold plus margin is kept one bit wider so it never wraps.
      low_limit  = low_ext + (THRESH_W+1)'(cfg.low_margin);
      shut_limit = shut_ext + (THRESH_W+1)'(cfg.shut_margin);

      low_cnt_in  = low_cnt_ff;
      low_clr_in  = low_clr_ff;
      shut_cnt_in = shut_cnt_ff;
      shut_clr_in = shut_clr_ff;
      alarms_in   = alarms_ff;

      if (step) begin
         // Undervoltage window lies strictly between the two thresholds.
         if (volt_ext < low_ext && volt_ext > shut_ext) begin
            low_cnt_in = sat_inc(low_cnt_ff, cfg.qualify_count);
            low_clr_in = '0;
         end else if (volt_ext > low_limit) begin
            low_cnt_in = '0;
            low_clr_in = sat_inc(low_clr_ff, cfg.qualify_count);
         end
         if (low_cnt_in >= cfg.qualify_count) begin
            alarms_in.low  = 1'b1;
            alarms_in.shut = 1'b0;
         end else if (low_clr_in >= cfg.qualify_count) begin
            alarms_in.low  = 1'b0;
         end

         // Power-cut is evaluated last, so it overrides the undervoltage result.
         if (volt_ext < shut_ext) begin
            shut_cnt_in = sat_inc(shut_cnt_ff, cfg.qualify_count);
            shut_clr_in = '0;
         end else if (volt_ext > shut_limit) begin
            shut_cnt_in = '0;
            shut_clr_in = sat_inc(shut_clr_ff, cfg.qualify_count);
         end
         if (shut_cnt_in >= cfg.qualify_count) begin
            alarms_in.shut = 1'b1;
            alarms_in.low  = 1'b0;
         end else if (shut_clr_in >= cfg.qualify_count) begin
            alarms_in.shut = 1'b0;
         end
      end
   end

   assign alarms_next = alarms_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_cnt_ff  <= '0;
         low_clr_ff  <= '0;
         shut_cnt_ff <= '0;
         shut_clr_ff <= '0;
         alarms_ff   <= '0;
      end else begin
         low_cnt_ff  <= low_cnt_in;
         low_clr_ff  <= low_clr_in;
         shut_cnt_ff <= shut_cnt_in;
         shut_clr_ff <= shut_clr_in;
         alarms_ff   <= alarms_in;
      end
   end

endmodule
